// File: rtl/core/median_select_of_five_macros.svh
// ----------------------------------------------------------------------------
// median_select_of_five_macros.svh
// Assertion helpers for the checker file of the median selector.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_SELECT_OF_FIVE_MACROS_SVH
`define MEDIAN_SELECT_OF_FIVE_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define MSF_ASSERT_RST(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define MSF_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/core/msf_pkg.sv
// ----------------------------------------------------------------------------
// msf_pkg
// Shared constants and control type of the median selector.
// ----------------------------------------------------------------------------
`default_nettype none

package msf_pkg;

  localparam int NUM_SAMPLES = 5;
  localparam int COUNT_WIDTH = 3;
  // each cell runs an even and an odd compare layer
  localparam int NUM_CELLS   = (NUM_SAMPLES + 1) / 2;
  // cells plus the output register
  localparam int LATENCY     = NUM_CELLS + 1;

  localparam logic [COUNT_WIDTH-1:0] MAX_COUNT = COUNT_WIDTH'(NUM_SAMPLES);

  typedef struct packed {
    logic                   vld;
    logic                   bias;
    logic [COUNT_WIDTH-1:0] cnt;
  } msf_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/median_select_of_five.sv
// ----------------------------------------------------------------------------
// median_select_of_five
// Order-statistic selector: sorted element at position count/2 of up to
// five samples, unsigned or signed order.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_value_0..4 and in_valid_count and raise start; a transfer
//   happens at every rising edge with start high and busy low. busy is always
//   low, so a new sample set may be given in every cycle.
//   Output: out_valid is high for one cycle with out_median. After the
//   input transfer a sample set passes the three sorter cells and then the
//   output register. Throughput is one result per cycle; the cell row is a pure
//   pipeline, so each cell works on a different sample set.
//   Only the first in_valid_count samples count; counts above five act as
//   five, a count of zero yields zero. Padding entries carry a high flag bit
//   so they sort above every real sample.
//   Config: cfg_we writes cfg_wdata into the signed-compare bit (0 unsigned,
//   1 two's complement). The bit is latched with each transfer, so an item
//   in flight keeps the order it entered with.
//   Reset (rst_n low, synchronous) clears the pipeline valid bits and the
//   signed-compare bit. The receiver cannot stall: each result is offered
//   for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module median_select_of_five
  import msf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [SAMPLE_WIDTH-1:0] in_value_0,
  input  wire logic [SAMPLE_WIDTH-1:0] in_value_1,
  input  wire logic [SAMPLE_WIDTH-1:0] in_value_2,
  input  wire logic [SAMPLE_WIDTH-1:0] in_value_3,
  input  wire logic [SAMPLE_WIDTH-1:0] in_value_4,
  input  wire logic [COUNT_WIDTH-1:0]  in_valid_count,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_wdata,
  output logic                         out_valid,
  output logic [SAMPLE_WIDTH-1:0]      out_median
);

  logic                                   signed_compare_r;
  logic [NUM_SAMPLES-1:0][SAMPLE_WIDTH-1:0] raw;
  logic [SAMPLE_WIDTH-1:0]                bias_mask;
  logic [COUNT_WIDTH-1:0]                 cnt_clamp;

  // per-cell data: index 0 is the prepared input, index k the output of cell k-1
  msf_ctl_t                               ctl_s  [NUM_CELLS+1];
  logic [NUM_SAMPLES-1:0][SAMPLE_WIDTH:0] keys_s [NUM_CELLS+1];

  logic                                   out_valid_r;
  logic [SAMPLE_WIDTH-1:0]                out_median_r;
  logic [SAMPLE_WIDTH-1:0]                out_median_nxt;
  logic [COUNT_WIDTH-1:0]                 sel_idx;
  logic [SAMPLE_WIDTH-1:0]                last_bias;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_compare_r <= 1'b0;
    end else if (cfg_we) begin
      signed_compare_r <= cfg_wdata;
    end
  end

  assign raw = {in_value_4, in_value_3, in_value_2, in_value_1, in_value_0};
  // flipping the sign bit maps signed order onto unsigned order
  assign bias_mask = {signed_compare_r, {(SAMPLE_WIDTH-1){1'b0}}};
  assign cnt_clamp = (in_valid_count > MAX_COUNT) ? MAX_COUNT : in_valid_count;

  always_comb begin
    ctl_s[0].vld  = start & ~busy;
    ctl_s[0].bias = signed_compare_r;
    ctl_s[0].cnt  = cnt_clamp;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      // flag bit on top pushes unused entries to the end
      keys_s[0][i] = {(COUNT_WIDTH'(i) >= cnt_clamp), raw[i] ^ bias_mask};
    end
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    msf_sort_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl_s[k]),
      .keys_i (keys_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .keys_o (keys_s[k+1])
    );
  end

  // pick position count/2 and undo the bias
  assign sel_idx   = ctl_s[NUM_CELLS].cnt >> 1;
  assign last_bias = {ctl_s[NUM_CELLS].bias, {(SAMPLE_WIDTH-1){1'b0}}};

  always_comb begin
    if (ctl_s[NUM_CELLS].cnt == '0) begin
      out_median_nxt = '0;
    end else begin
      out_median_nxt = keys_s[NUM_CELLS][sel_idx][SAMPLE_WIDTH-1:0] ^ last_bias;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_s[NUM_CELLS].vld;
    end
    out_median_r <= out_median_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

endmodule

`default_nettype wire

// File: rtl/core/msf_sort_cell.sv
// ----------------------------------------------------------------------------
// msf_sort_cell
// One pipeline cell of the odd-even transposition sorter: an even and an odd
// compare-exchange layer, then a register.
// ----------------------------------------------------------------------------
`default_nettype none

module msf_sort_cell
  import msf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire msf_ctl_t                                 ctl_i,
  input  wire logic [NUM_SAMPLES-1:0][SAMPLE_WIDTH:0]   keys_i,
  output msf_ctl_t                                      ctl_o,
  output logic      [NUM_SAMPLES-1:0][SAMPLE_WIDTH:0]   keys_o
);

  logic [NUM_SAMPLES-1:0][SAMPLE_WIDTH:0] mid;
  logic [NUM_SAMPLES-1:0][SAMPLE_WIDTH:0] keys_nxt;
  logic [NUM_SAMPLES-1:0][SAMPLE_WIDTH:0] keys_r;
  msf_ctl_t                               ctl_r;

  always_comb begin
    mid = keys_i;
    for (int i = 0; i + 1 < NUM_SAMPLES; i += 2) begin
      if (keys_i[i] > keys_i[i+1]) begin
        mid[i]   = keys_i[i+1];
        mid[i+1] = keys_i[i];
      end
    end
    keys_nxt = mid;
    for (int i = 1; i + 1 < NUM_SAMPLES; i += 2) begin
      if (mid[i] > mid[i+1]) begin
        keys_nxt[i]   = mid[i+1];
        keys_nxt[i+1] = mid[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= ctl_i.vld;
    end
    ctl_r.bias <= ctl_i.bias;
    ctl_r.cnt  <= ctl_i.cnt;
    keys_r     <= keys_nxt;
  end

  assign ctl_o  = ctl_r;
  assign keys_o = keys_r;

endmodule

`default_nettype wire

// File: rtl/core/msf_checker.sv
// ----------------------------------------------------------------------------
// msf_checker
// Port-level checks of the median selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "median_select_of_five_macros.svh"

module msf_checker
  import msf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic [COUNT_WIDTH-1:0]  in_valid_count,
  input wire logic                    out_valid,
  input wire logic [SAMPLE_WIDTH-1:0] out_median
);

  logic xfer;
  logic xfer_empty;
  logic median_zero;
  assign xfer        = start && !busy;
  assign xfer_empty  = xfer && (in_valid_count == '0);
  assign median_zero = (out_median == '0);

  `MSF_ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy raised")
  `MSF_ASSERT_RST(a_result_follows, clk, rst_n, xfer |-> ##LATENCY out_valid, "result lost")
  `MSF_ASSERT_RST(a_no_spurious, clk, rst_n, out_valid |-> $past(xfer, LATENCY), "extra result")
  `MSF_ASSERT_RST(a_empty_zero, clk, rst_n, xfer_empty |-> ##LATENCY median_zero, "empty set")

endmodule

bind median_select_of_five msf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_msf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_valid_count (in_valid_count),
  .out_valid      (out_valid),
  .out_median     (out_median)
);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for median_select_of_five. An initial block queues
// sample sets, signed-compare writes and drain points. A clocked driver issues
// them with random gaps. A clocked monitor compares every out_median against
// an in-bench selector model that keeps its own copy of the compare mode.
// ----------------------------------------------------------------------------

module testbench;
  import msf_pkg::*;

  localparam int SW = 16;

  // Kinds of queued work for the driver.
  typedef enum logic [1:0] {
    CMD_SAMPLES,  // one sample set transfer
    CMD_CONFIG,   // signed-compare write, issued only when the pipe is empty
    CMD_DRAIN     // hold off until every expected median has come back
  } cmd_kind_t;

  typedef struct {
    cmd_kind_t                         kind;
    logic [NUM_SAMPLES-1:0][SW-1:0]    samples;
    logic [COUNT_WIDTH-1:0]            count;
    logic                              cfg_bit;
    int                                gap;  // idle cycles after this transfer
  } bench_cmd_t;

  // Clock and reset.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Block inputs, known from time zero.
  logic                           start     = 1'b0;
  logic [NUM_SAMPLES-1:0][SW-1:0] drv_samples = '0;
  logic [COUNT_WIDTH-1:0]         drv_count = '0;
  logic                           cfg_we    = 1'b0;
  logic                           cfg_wdata = 1'b0;

  // Block outputs.
  logic          busy;
  logic          out_valid;
  logic [SW-1:0] out_median;

  bench_cmd_t    pending_cmds[$];
  logic [SW-1:0] expected_medians[$];
  int            gap_left      = 0;
  logic          signed_shadow = 1'b0;  // bench copy of the compare mode
  int            error_count   = 0;

  median_select_of_five #(
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value_0    (drv_samples[0]),
    .in_value_1    (drv_samples[1]),
    .in_value_2    (drv_samples[2]),
    .in_value_3    (drv_samples[3]),
    .in_value_4    (drv_samples[4]),
    .in_valid_count(drv_count),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_median    (out_median)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Reset held from time zero, released once and never asserted again.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Selector model: sort the leading samples by key, pick index count/2.
  // Signed order is unsigned order with the sign bit flipped. A count above
  // five acts as five; an empty set gives zero.
  // --------------------------------------------------------------------------
  function automatic logic [SW-1:0] select_median(
    input logic [NUM_SAMPLES-1:0][SW-1:0] s,
    input logic [COUNT_WIDTH-1:0]         count,
    input logic                           as_signed
  );
    logic [SW-1:0] keys [NUM_SAMPLES];
    logic [SW-1:0] flip;
    logic [SW-1:0] k;
    int            n;
    int            j;
    flip = as_signed ? {1'b1, {(SW-1){1'b0}}} : '0;
    n    = (count > MAX_COUNT) ? NUM_SAMPLES : int'(count);
    if (n == 0) return '0;
    for (int i = 0; i < n; i++) keys[i] = s[i] ^ flip;
    for (int i = 1; i < n; i++) begin
      k = keys[i];
      j = i;
      while (j > 0 && keys[j-1] > k) begin
        keys[j] = keys[j-1];
        j--;
      end
      keys[j] = k;
    end
    return keys[n/2] ^ flip;
  endfunction

  // --------------------------------------------------------------------------
  // Driver. One NBA per signal per edge: the next start is worked out first
  // and assigned once, so a held start never drops and rises in one step.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    bit         took;
    logic       nxt_start;
    logic       nxt_we;
    bench_cmd_t cmd;
    if (!rst_n) begin
      start         <= 1'b0;
      cfg_we        <= 1'b0;
      gap_left      = 0;
      signed_shadow = 1'b0;
    end else begin
      took = start && !busy;
      // A write lands at this edge; later transfers see the new mode.
      if (cfg_we) signed_shadow = cfg_wdata;
      if (took)
        expected_medians.push_back(select_median(drv_samples, drv_count, signed_shadow));
      nxt_start = start && !took;
      nxt_we    = 1'b0;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          cmd = pending_cmds[0];
          case (cmd.kind)
            CMD_SAMPLES: begin
              drv_samples <= cmd.samples;
              drv_count   <= cmd.count;
              nxt_start   = 1'b1;
              gap_left    = cmd.gap;
              void'(pending_cmds.pop_front());
            end
            CMD_CONFIG: begin
              // every transfer yields a result, so an empty queue means idle
              if (expected_medians.size() == 0 && !took) begin
                cfg_wdata <= cmd.cfg_bit;
                nxt_we    = 1'b1;
                void'(pending_cmds.pop_front());
              end
            end
            CMD_DRAIN: begin
              if (expected_medians.size() == 0 && !took)
                void'(pending_cmds.pop_front());
            end
            default: void'(pending_cmds.pop_front());
          endcase
        end
      end
      start  <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each out_valid cycle is one result transfer, checked in order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    logic [SW-1:0] want;
    if (rst_n && out_valid) begin
      if (expected_medians.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual median %h",
                 $time, out_median);
        error_count++;
      end else begin
        want = expected_medians.pop_front();
        if (out_median !== want) begin
          $display("%0t: median mismatch, expected %h, actual %h",
                   $time, want, out_median);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_samples(input logic [NUM_SAMPLES-1:0][SW-1:0] s,
                             input logic [COUNT_WIDTH-1:0] c, input int gap);
    bench_cmd_t cmd;
    cmd.kind    = CMD_SAMPLES;
    cmd.samples = s;
    cmd.count   = c;
    cmd.cfg_bit = 1'b0;
    cmd.gap     = gap;
    pending_cmds.push_back(cmd);
  endtask

  task automatic add_marker(input cmd_kind_t kind, input logic bit_val);
    bench_cmd_t cmd;
    cmd.kind    = kind;
    cmd.samples = '0;
    cmd.count   = '0;
    cmd.cfg_bit = bit_val;
    cmd.gap     = 0;
    pending_cmds.push_back(cmd);
  endtask

  // Bias toward the sign boundary, the extremes and small values near zero
  // so that ties and sign-dependent orderings turn up often.
  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4, 5:    return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [NUM_SAMPLES-1:0][SW-1:0] s;
    int                             c;
    int                             gap;

    // Directed: same sets under both compare modes. Packed literals list
    // sample 4 first, sample 0 last.
    for (int mode = 0; mode < 2; mode++) begin
      add_marker(CMD_CONFIG, mode[0]);
      add_samples({5{16'hFFFF}}, 3'd5, 0);
      add_samples({5{16'h0000}}, 3'd5, 1);
      add_samples({16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h0000}, 3'd5, 0);
      add_samples({16'h1234, 16'hBEEF, 16'h8000, 16'h7FFF, 16'hFFFF}, 3'd0, 2);  // empty set
      add_samples({16'h0003, 16'hFFFE, 16'h8001, 16'h7FFE, 16'h0100}, 3'd6, 0);  // clamped
      add_samples({16'hFFFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h0042}, 3'd7, 0);  // clamped
      add_samples({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8001}, 3'd1, 3);
      add_samples({16'h0000, 16'h0000, 16'h0000, 16'hFFF0, 16'h0010}, 3'd2, 0);  // upper middle
      add_samples({16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000}, 3'd3, 4);
      add_samples({16'h0000, 16'hC000, 16'h4000, 16'h0001, 16'hFFFF}, 3'd4, 0);
      add_samples({16'h0009, 16'h0005, 16'h0005, 16'h0005, 16'h0001}, 3'd5, 0);  // ties
      add_samples({16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005}, 3'd5, 1);  // descending
    end
    // Pipe must drain fully at least once before more traffic.
    add_marker(CMD_DRAIN, 1'b0);

    // Random phases, alternating compare mode; stretches of back-to-back
    // transfers alternate with stretches of random gaps.
    for (int phase = 0; phase < 4; phase++) begin
      add_marker(CMD_CONFIG, phase[0] ^ 1'b1);
      for (int i = 0; i < 412; i++) begin
        for (int k = 0; k < NUM_SAMPLES; k++) s[k] = rand_sample();
        c   = $urandom_range(0, 9);
        gap = ((i / 40) % 2 == phase % 2) ? 0 : $urandom_range(0, 4);
        add_samples(s, (c > 7) ? 3'd5 : 3'(c), gap);
        if (i == 200) add_marker(CMD_DRAIN, 1'b0);
      end
    end

    // Wait for the driver to issue everything, then for the pipe to empty.
    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (error_count == 0 && expected_medians.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: fails the test if it runs far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/msf_pkg.sv
rtl/core/msf_sort_cell.sv
rtl/core/median_select_of_five.sv
rtl/core/msf_checker.sv
bench/testbench.sv
